// ===== src/stn_pkg.sv =====
// ----------------------------------------------------------------------------
// stn_pkg
// Shared types and constants of the search token normalizer.
// ----------------------------------------------------------------------------
package stn_pkg;

    localparam int HELD_DEPTH_DEF = 16;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_HASH   = 8'd35;
    localparam logic [7:0] CHAR_DOLLAR = 8'd36;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CASE_BIT    = 8'h20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROC,
        ST_EMIT,
        ST_FSTART,
        ST_FLUSH,
        ST_CLOSE
    } stn_state_t;

    // what the current byte does to the token
    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_PEND,
        CLS_HOLD,
        CLS_ALNUM
    } stn_class_t;

    typedef struct packed {
        logic accept;
        logic proc_pend;
        logic proc_hold;
        logic proc_alnum;
        logic emit_byte;
        logic flush_start;
        logic flush_push;
        logic flush_done;
        logic close;
    } stn_cmd_t;

    typedef struct packed {
        stn_class_t cls;
        logic       is_last;
        logic       is_plus;
        logic       held_empty;
        logic       flush_last;
        logic       out_free;
    } stn_status_t;

endpackage

// ===== src/stn_datapath.sv =====
// ----------------------------------------------------------------------------
// stn_datapath
// Byte register, word flags, trailing byte store and output register.
// ----------------------------------------------------------------------------
module stn_datapath #(
    parameter int HELD_DEPTH = stn_pkg::HELD_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  stn_pkg::stn_cmd_t    cmd,
    output stn_pkg::stn_status_t status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast,
    output logic [2:0]           m_tuser
);

    localparam int IDX_W = $clog2(HELD_DEPTH);
    localparam int CNT_W = $clog2(HELD_DEPTH + 1);

    function automatic logic f_digit(input logic [7:0] b);
        f_digit = (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic f_alpha(input logic [7:0] b);
        f_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    logic [7:0]       held_mem [HELD_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] rd_addr;

    logic [7:0]       byte_reg;
    logic             last_reg;

    logic [CNT_W-1:0] held_count_reg, held_count_next;
    logic [IDX_W-1:0] flush_idx_reg, flush_idx_next;
    logic             token_started_reg, token_started_next;
    logic             last_digit_reg, last_digit_next;
    logic             comma_pend_reg, comma_pend_next;
    logic [1:0]       raw_count_reg, raw_count_next;
    logic             first_na_reg, first_na_next;
    logic             overflow_reg, overflow_next;
    logic             emitted_reg, emitted_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg;
    logic             out_last_reg;
    logic [2:0]       out_user_reg;

    logic             hold_req;
    logic             hold_ok;
    logic             hold_we;
    logic [7:0]       hold_data;
    logic             b_alnum;
    logic             b_skip;
    logic             b_keep;
    logic             kept;
    logic [7:0]       low_byte;

    // classification of the registered byte
    always_comb begin
        b_alnum = f_digit(byte_reg) || f_alpha(byte_reg);
        b_skip  = (byte_reg == stn_pkg::CHAR_SPACE) || byte_reg[7];
        b_keep  = token_started_reg || b_alnum || (byte_reg == stn_pkg::CHAR_HASH) ||
                  (byte_reg == stn_pkg::CHAR_DOLLAR);
        if (b_skip || !b_keep) begin
            status.cls = stn_pkg::CLS_NONE;
        end else if ((byte_reg == stn_pkg::CHAR_COMMA) && token_started_reg &&
                     last_digit_reg && !last_reg) begin
            status.cls = stn_pkg::CLS_PEND;
        end else if (b_alnum) begin
            status.cls = stn_pkg::CLS_ALNUM;
        end else begin
            status.cls = stn_pkg::CLS_HOLD;
        end
        status.is_last    = last_reg;
        status.is_plus    = (byte_reg == stn_pkg::CHAR_PLUS);
        status.held_empty = (held_count_reg == '0);
        status.flush_last = ((CNT_W'(flush_idx_reg) + 1'b1) == held_count_reg);
        status.out_free   = !out_valid_reg || m_tready;
    end

    assign low_byte = f_alpha(byte_reg) ? (byte_reg | stn_pkg::CASE_BIT) : byte_reg;
    assign kept     = emitted_reg && !((raw_count_reg == 2'd1) && first_na_reg);

    // trailing store write: a pending comma on accept, or a held byte
    assign hold_req  = (cmd.accept && comma_pend_reg && !f_digit(s_tdata)) || cmd.proc_hold;
    assign hold_data = cmd.accept ? stn_pkg::CHAR_COMMA : byte_reg;
    assign hold_ok   = (held_count_reg < CNT_W'(HELD_DEPTH));
    assign hold_we   = hold_req && hold_ok;

    always_comb begin
        if (cmd.flush_start) begin
            rd_addr = '0;
        end else if (cmd.flush_push) begin
            rd_addr = flush_idx_reg + 1'b1;
        end else begin
            rd_addr = flush_idx_reg;
        end
    end

    always_comb begin
        held_count_next    = held_count_reg;
        flush_idx_next     = flush_idx_reg;
        token_started_next = token_started_reg;
        last_digit_next    = last_digit_reg;
        comma_pend_next    = comma_pend_reg;
        raw_count_next     = raw_count_reg;
        first_na_next      = first_na_reg;
        overflow_next      = overflow_reg;
        emitted_next       = emitted_reg;

        if (cmd.accept) begin
            comma_pend_next = 1'b0;
            if (raw_count_reg == 2'd0) begin
                first_na_next = !(f_digit(s_tdata) || f_alpha(s_tdata));
            end
            if (raw_count_reg != 2'd2) begin
                raw_count_next = raw_count_reg + 2'd1;
            end
        end
        if (hold_req) begin
            last_digit_next = 1'b0;
            if (hold_ok) begin
                held_count_next = held_count_reg + 1'b1;
            end else begin
                overflow_next = 1'b1;
            end
        end
        if (cmd.proc_pend) begin
            comma_pend_next = 1'b1;
        end
        if (cmd.proc_hold) begin
            token_started_next = 1'b1;
        end
        if (cmd.proc_alnum) begin
            token_started_next = 1'b1;
            last_digit_next    = f_digit(byte_reg);
        end
        if (cmd.flush_start) begin
            flush_idx_next = '0;
        end
        if (cmd.flush_push) begin
            flush_idx_next = flush_idx_reg + 1'b1;
            emitted_next   = 1'b1;
        end
        if (cmd.flush_done) begin
            held_count_next = '0;
        end
        if (cmd.emit_byte) begin
            emitted_next = 1'b1;
        end
        if (cmd.close) begin
            held_count_next    = '0;
            token_started_next = 1'b0;
            last_digit_next    = 1'b0;
            comma_pend_next    = 1'b0;
            raw_count_next     = 2'd0;
            first_na_next      = 1'b0;
            overflow_next      = 1'b0;
            emitted_next       = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.flush_push || cmd.emit_byte || cmd.close) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg    <= '0;
            flush_idx_reg     <= '0;
            token_started_reg <= 1'b0;
            last_digit_reg    <= 1'b0;
            comma_pend_reg    <= 1'b0;
            raw_count_reg     <= 2'd0;
            first_na_reg      <= 1'b0;
            overflow_reg      <= 1'b0;
            emitted_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            held_count_reg    <= held_count_next;
            flush_idx_reg     <= flush_idx_next;
            token_started_reg <= token_started_next;
            last_digit_reg    <= last_digit_next;
            comma_pend_reg    <= comma_pend_next;
            raw_count_reg     <= raw_count_next;
            first_na_reg      <= first_na_next;
            overflow_reg      <= overflow_next;
            emitted_reg       <= emitted_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hold_we) begin
            held_mem[held_count_reg[IDX_W-1:0]] <= hold_data;
        end
        rd_data_reg <= held_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (cmd.flush_push) begin
            out_data_reg <= rd_data_reg;
            out_last_reg <= 1'b0;
            out_user_reg <= 3'b001;
        end else if (cmd.emit_byte) begin
            out_data_reg <= low_byte;
            out_last_reg <= 1'b0;
            out_user_reg <= 3'b001;
        end else if (cmd.close) begin
            out_data_reg <= '0;
            out_last_reg <= 1'b1;
            out_user_reg <= {overflow_reg, kept, 1'b0};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== src/stn_ctrl.sv =====
// ----------------------------------------------------------------------------
// stn_ctrl
// Sequencer: accept, classify, flush held bytes, emit byte, close the word.
// ----------------------------------------------------------------------------
module stn_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output stn_pkg::stn_cmd_t    cmd,
    input  stn_pkg::stn_status_t status
);

    stn_pkg::stn_state_t state_reg, state_next;
    logic                to_emit_reg, to_emit_next;

    always_comb begin
        state_next   = state_reg;
        to_emit_next = to_emit_reg;
        unique case (state_reg)
            stn_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = stn_pkg::ST_PROC;
                end
            end
            stn_pkg::ST_PROC: begin
                to_emit_next = (status.cls == stn_pkg::CLS_ALNUM);
                if (status.cls == stn_pkg::CLS_ALNUM) begin
                    if (!status.held_empty) begin
                        state_next = stn_pkg::ST_FSTART;
                    end else if (!status.out_free) begin
                        state_next = stn_pkg::ST_EMIT;
                    end else if (status.is_last) begin
                        state_next = stn_pkg::ST_CLOSE;
                    end else begin
                        state_next = stn_pkg::ST_IDLE;
                    end
                end else if (status.is_last && status.is_plus) begin
                    state_next = stn_pkg::ST_FSTART;
                end else if (status.is_last) begin
                    state_next = stn_pkg::ST_CLOSE;
                end else begin
                    state_next = stn_pkg::ST_IDLE;
                end
            end
            stn_pkg::ST_FSTART: begin
                if (!status.held_empty) begin
                    state_next = stn_pkg::ST_FLUSH;
                end else if (to_emit_reg) begin
                    state_next = stn_pkg::ST_EMIT;
                end else begin
                    state_next = stn_pkg::ST_CLOSE;
                end
            end
            stn_pkg::ST_FLUSH: begin
                if (status.out_free && status.flush_last) begin
                    state_next = to_emit_reg ? stn_pkg::ST_EMIT : stn_pkg::ST_CLOSE;
                end
            end
            stn_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    state_next = status.is_last ? stn_pkg::ST_CLOSE : stn_pkg::ST_IDLE;
                end
            end
            stn_pkg::ST_CLOSE: begin
                if (status.out_free) begin
                    state_next = stn_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stn_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            stn_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            stn_pkg::ST_PROC: begin
                cmd.proc_pend  = (status.cls == stn_pkg::CLS_PEND);
                cmd.proc_hold  = (status.cls == stn_pkg::CLS_HOLD);
                cmd.proc_alnum = (status.cls == stn_pkg::CLS_ALNUM);
                cmd.emit_byte  = (status.cls == stn_pkg::CLS_ALNUM) && status.held_empty &&
                                 status.out_free;
            end
            stn_pkg::ST_FSTART: begin
                cmd.flush_start = 1'b1;
            end
            stn_pkg::ST_FLUSH: begin
                cmd.flush_push = status.out_free;
                cmd.flush_done = status.out_free && status.flush_last;
            end
            stn_pkg::ST_EMIT: begin
                cmd.emit_byte = status.out_free;
            end
            stn_pkg::ST_CLOSE: begin
                cmd.close = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= stn_pkg::ST_IDLE;
            to_emit_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            to_emit_reg <= to_emit_next;
        end
    end

endmodule

// ===== src/search_token_normalizer.sv =====
// ----------------------------------------------------------------------------
// search_token_normalizer
// Cleans a raw search word, fed one byte per request, into a token stream.
// ----------------------------------------------------------------------------
// A plain byte is accepted in IDLE and classified in PROC, where a letter
// or digit with nothing held is loaded into the output register. A letter
// or digit that releases held trailing bytes is accepted and classified,
// then FSTART starts the store read, FLUSH pushes each held byte and EMIT
// loads the byte itself. A final '+' releases them the same way, and passes
// through FSTART even when nothing is held. Each word ends with a closing
// request (m_tlast high) from CLOSE. Any step that loads the output register
// waits while the output side holds m_tready low and the register is full.
// The store holds HELD_DEPTH trailing bytes; further ones are dropped and
// flagged at the word's end.
// ----------------------------------------------------------------------------
module search_token_normalizer #(
    parameter int HELD_DEPTH = stn_pkg::HELD_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // token_end
    output logic [2:0] m_tuser    // [0] byte_valid, [1] token_kept, [2] held_overflow
);

    stn_pkg::stn_cmd_t    cmd;
    stn_pkg::stn_status_t status;

    stn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    stn_datapath #(
        .HELD_DEPTH (HELD_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== test/search_token_normalizer_check.sv =====
// ----------------------------------------------------------------------------
// search_token_normalizer_check
// Watches both channels of the normalizer, predicts the token stream of every
// accepted request and compares each result, field by field, in order.
// ----------------------------------------------------------------------------
module search_token_normalizer_check #(
    parameter int HELD_DEPTH = stn_pkg::HELD_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // is_last
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic       m_tlast,   // token_end
    input  logic [2:0] m_tuser,   // [0] byte_valid, [1] token_kept, [2] held_overflow
    output int         fail_count,
    output int         pending_results,
    output int         results_checked
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_end;
        logic       token_kept;
        logic       held_overflow;
    } token_result_t;

    logic [7:0]    trail_store [HELD_DEPTH];
    int            trail_count;
    bit            token_started;
    bit            last_kept_digit;
    bit            comma_waiting;
    logic [1:0]    raw_seen;
    bit            first_not_alnum;
    bit            trail_overflow;
    bit            emitted_any;
    token_result_t token_q[$];
    token_result_t got;
    token_result_t want;
    int            errors;
    int            matched;

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_alnum(logic [7:0] b);
        return is_digit(b) || is_alpha(b);
    endfunction

    task automatic hold_trailing(logic [7:0] b);
        if (trail_count < HELD_DEPTH) begin
            trail_store[trail_count] = b;
            trail_count++;
        end else begin
            trail_overflow = 1'b1;
        end
        last_kept_digit = 1'b0;
    endtask

    task automatic release_trailing();
        for (int i = 0; i < trail_count; i++) begin
            token_q.push_back('{trail_store[i], 1'b1, 1'b0, 1'b0, 1'b0});
            emitted_any = 1'b1;
        end
        trail_count = 0;
    endtask

    task automatic clear_word();
        trail_count     = 0;
        token_started   = 1'b0;
        last_kept_digit = 1'b0;
        comma_waiting   = 1'b0;
        raw_seen        = 2'd0;
        first_not_alnum = 1'b0;
        trail_overflow  = 1'b0;
        emitted_any     = 1'b0;
    endtask

    task automatic normalize_request(logic [7:0] b, logic last);
        bit keep;
        bit kept;
        if (comma_waiting) begin
            comma_waiting = 1'b0;
            if (!is_digit(b))
                hold_trailing(stn_pkg::CHAR_COMMA);
        end
        if (raw_seen == 2'd0)
            first_not_alnum = !is_alnum(b);
        if (raw_seen < 2'd2)
            raw_seen++;
        if (b != stn_pkg::CHAR_SPACE && b < 8'd128) begin
            keep = token_started || is_alnum(b) || b == stn_pkg::CHAR_HASH
                   || b == stn_pkg::CHAR_DOLLAR;
            if (keep) begin
                if (b == stn_pkg::CHAR_COMMA && token_started && last_kept_digit
                    && !last) begin
                    comma_waiting = 1'b1;
                end else if (is_alnum(b)) begin
                    release_trailing();
                    token_q.push_back('{is_alpha(b) ? (b | stn_pkg::CASE_BIT) : b,
                                        1'b1, 1'b0, 1'b0, 1'b0});
                    emitted_any     = 1'b1;
                    last_kept_digit = is_digit(b);
                    token_started   = 1'b1;
                end else begin
                    hold_trailing(b);
                    token_started = 1'b1;
                end
            end
        end
        if (last) begin
            if (b == stn_pkg::CHAR_PLUS)
                release_trailing();
            kept = emitted_any && !(raw_seen == 2'd1 && first_not_alnum);
            token_q.push_back('{8'd0, 1'b0, 1'b1, kept, trail_overflow});
            clear_word();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_word();
            token_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                normalize_request(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1], m_tuser[2]};
                if (token_q.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result: byte %h valid %b end %b kept %b ovf %b",
                                 got.out_byte, got.byte_valid, got.token_end,
                                 got.token_kept, got.held_overflow);
                    errors++;
                end else begin
                    want = token_q.pop_front();
                    matched++;
                    if (got.out_byte !== want.out_byte
                        || got.byte_valid !== want.byte_valid
                        || got.token_end !== want.token_end
                        || got.token_kept !== want.token_kept
                        || got.held_overflow !== want.held_overflow) begin
                        if (errors < 10)
                            $display({"mismatch (exp/got): byte %h/%h valid %b/%b ",
                                      "end %b/%b kept %b/%b ovf %b/%b"},
                                     want.out_byte, got.out_byte,
                                     want.byte_valid, got.byte_valid,
                                     want.token_end, got.token_end,
                                     want.token_kept, got.token_kept,
                                     want.held_overflow, got.held_overflow);
                        errors++;
                    end
                end
            end
        end
        fail_count      <= errors;
        pending_results <= token_q.size();
        results_checked <= matched;
    end

endmodule

// ===== test/search_token_normalizer_test.sv =====
// ----------------------------------------------------------------------------
// search_token_normalizer_test
// Feeds directed and random words through the normalizer under changing
// sender idle and receiver stall patterns; the checker scores the results.
// ----------------------------------------------------------------------------
module search_token_normalizer_test;

    localparam int REQUEST_TARGET = 210;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 40;

    typedef enum int {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } traffic_phase_t;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [2:0] m_tuser;

    int fail_count;
    int pending_results;
    int results_checked;

    int idle_pct;
    int stall_pct;
    int requests_sent;
    int words_sent;
    int cycle_count;
    logic [7:0] word_q[$];

    search_token_normalizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    search_token_normalizer_check token_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("search_token_normalizer test failed");
            $finish;
        end
    end

    task automatic set_phase(traffic_phase_t ph);
        case (ph)
            PH_FREE: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            PH_SEND_IDLE: begin
                idle_pct  = 84;
                stall_pct = 0;
            end
            PH_RECV_STALL: begin
                idle_pct  = 0;
                stall_pct = 84;
            end
            default: begin
                idle_pct  = 30;
                stall_pct = 30;
            end
        endcase
    endtask

    function automatic logic [7:0] random_char(int sel);
        string punct;
        punct = "!%&()*-./:;<=>?@[]^_{|}~";
        case (sel)
            0: return 8'($urandom_range("A", "Z"));
            1: return 8'($urandom_range("a", "z"));
            2: return 8'($urandom_range("0", "9"));
            3: return stn_pkg::CHAR_COMMA;
            4: return stn_pkg::CHAR_PLUS;
            5: return stn_pkg::CHAR_SPACE;
            6: return $urandom_range(1) ? stn_pkg::CHAR_HASH : stn_pkg::CHAR_DOLLAR;
            7: return 8'($urandom_range(127));
            8: return 8'($urandom_range(255, 128));
            default: return punct[$urandom_range(punct.len() - 1)];
        endcase
    endfunction

    // sends word_q as one word, tlast on its final byte
    task automatic send_word();
        int n;
        n = word_q.size();
        for (int i = 0; i < n; i++) begin
            while ($urandom_range(99) < idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= word_q[i];
            s_tlast  <= (i == n - 1);
            do @(posedge aclk); while (!s_tready);
            requests_sent++;
        end
        word_q.delete();
        words_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            word_q.push_back(s[i]);
        send_word();
    endtask

    task automatic send_random_word();
        int kind;
        int len;
        kind = $urandom_range(9);
        if (kind <= 5) begin
            // well formed start, mixed body
            len = $urandom_range(10, 1);
            word_q.push_back($urandom_range(3) == 0 ? random_char(6)
                                                    : random_char($urandom_range(2)));
            for (int i = 1; i < len; i++)
                word_q.push_back(random_char($urandom_range(9)));
            if ($urandom_range(3) == 0)
                word_q.push_back(stn_pkg::CHAR_PLUS);
        end else if (kind == 6) begin
            // long trailing run of 14 to 20 bytes, which can fill the store
            word_q.push_back(random_char(1));
            len = $urandom_range(20, 14);
            for (int i = 0; i < len; i++)
                word_q.push_back(random_char(9));
            case ($urandom_range(2))
                0: word_q.push_back(random_char(2));
                1: word_q.push_back(stn_pkg::CHAR_PLUS);
                default: word_q.push_back(random_char(9));
            endcase
        end else if (kind == 7) begin
            // digit groups with commas
            len = $urandom_range(8, 2);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: word_q.push_back(random_char(2));
                    6, 7, 8: word_q.push_back(stn_pkg::CHAR_COMMA);
                    default: word_q.push_back(random_char($urandom_range(9)));
                endcase
            end
        end else begin
            len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++)
                word_q.push_back(8'($urandom_range(255)));
        end
        send_word();
    endtask

    initial begin
        cycle_count   = 0;
        requests_sent = 0;
        words_sent    = 0;
        set_phase(PH_FREE);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_text("A");
        send_text("#");
        send_text("1,2");
        send_text("9,");
        send_text("C++");
        send_text(" $x!?");
        word_q.push_back(8'hFF);
        word_q.push_back(8'h80);
        word_q.push_back("z");
        word_q.push_back("0");
        word_q.push_back(8'h7F);
        send_word();
        word_q.push_back(8'h00);
        send_word();
        send_text(",a");

        while (requests_sent < REQUEST_TARGET) begin
            set_phase(traffic_phase_t'((words_sent / 5) % 4));
            send_random_word();
        end
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests in %0d words, %0d results checked", requests_sent,
                 words_sent, results_checked);
        $display("phases: free flow, sender idle, receiver stall, both");
        if (fail_count == 0 && pending_results == 0) begin
            $display("search_token_normalizer test passed");
        end else begin
            $display("search_token_normalizer test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/stn_pkg.sv
src/stn_datapath.sv
src/stn_ctrl.sv
src/search_token_normalizer.sv
test/search_token_normalizer_check.sv
test/search_token_normalizer_test.sv
